@@ hdl/spq_pkg.sv @@
// shared types and codes for the sorted priority queue
package spq_pkg;

  // widths fixed by the stream payload
  localparam int VALUE_BITS     = 32;
  localparam int PRIO_PORT_BITS = 16;
  localparam int OCC_BITS       = 5;

  // request kind carried in the slave-side tuser
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  // result kind carried in the master-side tuser
  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // broadcast control from the top level to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

@@ hdl/spq_cell.sv @@
// one slot of the sorted chain: holds an entry and trades it with its neighbors
module spq_cell #(
  parameter int PRIORITY_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  spq_pkg::cell_ctl_t                   ctl,
  input  logic signed [PRIORITY_BITS-1:0]      new_prio,
  input  logic [spq_pkg::VALUE_BITS-1:0]       new_value,
  input  logic                                 prev_keep,
  input  logic                                 prev_valid,
  input  logic signed [PRIORITY_BITS-1:0]      prev_prio,
  input  logic [spq_pkg::VALUE_BITS-1:0]       prev_value,
  input  logic                                 next_valid,
  input  logic signed [PRIORITY_BITS-1:0]      next_prio,
  input  logic [spq_pkg::VALUE_BITS-1:0]       next_value,
  output logic                                 valid,
  output logic signed [PRIORITY_BITS-1:0]      prio,
  output logic [spq_pkg::VALUE_BITS-1:0]       value,
  output logic                                 keep
);
  import spq_pkg::*;

  logic                           valid_next;
  logic signed [PRIORITY_BITS-1:0] prio_next;
  logic [VALUE_BITS-1:0]          value_next;

  // entry stays put on insert when it is served no later than the new one
  assign keep = valid && (prio <= new_prio);

  // choose this slot's next contents
  always_comb begin
    valid_next = valid;
    prio_next  = prio;
    value_next = value;
    if (ctl.ins && !keep) begin
      if (prev_keep) begin
        valid_next = 1'b1;
        prio_next  = new_prio;
        value_next = new_value;
      end else begin
        valid_next = prev_valid;
        prio_next  = prev_prio;
        value_next = prev_value;
      end
    end else if (ctl.rem) begin
      valid_next = next_valid;
      prio_next  = next_prio;
      value_next = next_value;
    end
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    prio  <= prio_next;
    value <= value_next;
  end

endmodule

@@ hdl/stable_priority_queue_unit.sv @@
// top level of the sorted priority queue built from a chain of slot cells
//
// Bounded priority queue of CAPACITY entries kept sorted in a row of slot
// cells; lower priority numbers leave first and equal priorities leave in
// arrival order. Each request (tuser 0 insert, 1 remove front) produces
// exactly one result. A request is taken every cycle while the result
// register is free or being emptied, and its result appears in the next
// cycle: the new priority is compared against all cells at once and every
// cell shifts by at most one place in that same cycle. Insert into a full
// queue returns status 3 and changes nothing; remove from an empty queue
// returns status 2. Priorities are PRIORITY_BITS-bit two's complement taken
// from the low bits of the request's priority field. No clearing pass is
// needed after reset.
module stable_priority_queue_unit #(
  parameter int CAPACITY      = 16,
  parameter int PRIORITY_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] item_value, [47:32] item_priority
  input  logic [47:0] s_axis_tdata,
  // [0] cmd
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] out_value, [47:32] out_priority, [52:48] occupancy, [55:53] zero
  output logic [55:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser
);
  import spq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  // request decode
  logic                            fire;
  logic                            is_insert;
  logic                            full;
  logic                            empty;
  cell_ctl_t                       ctl;
  logic signed [PRIORITY_BITS-1:0] new_prio;
  logic [VALUE_BITS-1:0]           new_value;

  // chain
  logic                            cell_valid [CAPACITY];
  logic signed [PRIORITY_BITS-1:0] cell_prio  [CAPACITY];
  logic [VALUE_BITS-1:0]           cell_value [CAPACITY];
  logic                            cell_keep  [CAPACITY];
  logic [CAPACITY-1:0]             valid_vec;

  // count and result
  logic [CW-1:0]                   count;
  logic [CW-1:0]                   count_next;
  logic [CW+OCC_BITS-1:0]          occ_wide;
  logic [PRIO_PORT_BITS-1:0]       front_prio;
  status_t                         status_next;
  logic [VALUE_BITS-1:0]           res_value_next;
  logic [PRIO_PORT_BITS-1:0]       res_prio_next;
  status_t                         res_status;
  logic [VALUE_BITS-1:0]           res_value;
  logic [PRIO_PORT_BITS-1:0]       res_prio;
  logic [OCC_BITS-1:0]             res_occ;

  // handshake: the result register is the only thing that can hold us up
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;
  assign is_insert     = (s_axis_tuser[0] == CMD_INSERT);
  assign full          = (count == FULL_COUNT);
  assign empty         = (count == '0);
  assign ctl.ins       = fire && is_insert && !full;
  assign ctl.rem       = fire && !is_insert && !empty;
  assign new_value     = s_axis_tdata[VALUE_BITS-1:0];

  // priority as stored, and the front priority as reported
  generate
    if (PRIORITY_BITS <= PRIO_PORT_BITS) begin : g_prio_in_narrow
      assign new_prio = s_axis_tdata[VALUE_BITS +: PRIORITY_BITS];
    end else begin : g_prio_in_wide
      assign new_prio = {{(PRIORITY_BITS-PRIO_PORT_BITS){1'b0}},
                         s_axis_tdata[VALUE_BITS +: PRIO_PORT_BITS]};
    end
    if (PRIORITY_BITS >= PRIO_PORT_BITS) begin : g_prio_out_wide
      assign front_prio = cell_prio[0][PRIO_PORT_BITS-1:0];
    end else begin : g_prio_out_narrow
      assign front_prio = {{(PRIO_PORT_BITS-PRIORITY_BITS){cell_prio[0][PRIORITY_BITS-1]}},
                           cell_prio[0]};
    end
  endgenerate

  // row of cells, front of the queue at cell 0
  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                            p_keep;
      logic                            p_valid;
      logic signed [PRIORITY_BITS-1:0] p_prio;
      logic [VALUE_BITS-1:0]           p_value;
      logic                            n_valid;
      logic signed [PRIORITY_BITS-1:0] n_prio;
      logic [VALUE_BITS-1:0]           n_value;

      if (i == 0) begin : g_head
        assign p_keep  = 1'b1;
        assign p_valid = 1'b0;
        assign p_prio  = '0;
        assign p_value = '0;
      end else begin : g_mid_prev
        assign p_keep  = cell_keep[i-1];
        assign p_valid = cell_valid[i-1];
        assign p_prio  = cell_prio[i-1];
        assign p_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
        assign n_valid = 1'b0;
        assign n_prio  = '0;
        assign n_value = '0;
      end else begin : g_mid_next
        assign n_valid = cell_valid[i+1];
        assign n_prio  = cell_prio[i+1];
        assign n_value = cell_value[i+1];
      end

      spq_cell #(
        .PRIORITY_BITS(PRIORITY_BITS)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .new_prio  (new_prio),
        .new_value (new_value),
        .prev_keep (p_keep),
        .prev_valid(p_valid),
        .prev_prio (p_prio),
        .prev_value(p_value),
        .next_valid(n_valid),
        .next_prio (n_prio),
        .next_value(n_value),
        .valid     (cell_valid[i]),
        .prio      (cell_prio[i]),
        .value     (cell_value[i]),
        .keep      (cell_keep[i])
      );

      assign valid_vec[i] = cell_valid[i];
    end
  endgenerate

  // next count and result fields
  always_comb begin
    count_next     = count;
    status_next    = ST_INSERTED;
    res_value_next = '0;
    res_prio_next  = '0;
    if (is_insert) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_INSERTED;
        count_next  = count + 1'b1;
      end
    end else begin
      if (empty) begin
        status_next = ST_UNDERFLOW;
      end else begin
        status_next    = ST_REMOVED;
        count_next     = count - 1'b1;
        res_value_next = cell_value[0];
        res_prio_next  = front_prio;
      end
    end
  end

  assign occ_wide = {{OCC_BITS{1'b0}}, count_next};

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      res_status <= status_next;
      res_value  <= res_value_next;
      res_prio   <= res_prio_next;
      res_occ    <= occ_wide[OCC_BITS-1:0];
    end
  end

  assign m_axis_tuser = res_status;
  assign m_axis_tdata = {3'b000, res_occ, res_prio, res_value};

  // count never runs past the chain length
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count above capacity");

  // occupied cells match the count
  a_count_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(count))
    else $error("cell valid flags disagree with entry count");

  // remove on an empty queue reports underflow next cycle
  a_underflow: assert property (@(posedge clk) disable iff (rst)
    fire && !is_insert && empty |=> m_axis_tvalid && m_axis_tuser == ST_UNDERFLOW)
    else $error("missing underflow result");

  // neighbors stay in priority order
  generate
    for (genvar j = 0; j + 1 < CAPACITY; j++) begin : g_order_chk
      a_sorted: assert property (@(posedge clk) disable iff (rst)
        cell_valid[j+1] |-> cell_valid[j] && (cell_prio[j] <= cell_prio[j+1]))
        else $error("chain out of order");
    end
  endgenerate

endmodule

@@ tb/tb.sv @@
// testbench for the sorted priority queue: random stream traffic checked against a sorted shadow queue
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 900;

  // one request waiting to go out on the slave side
  typedef struct {
    cmd_t        cmd;
    logic [31:0] value;
    logic [15:0] prio;
    bit          pause;
  } queue_req_t;

  // expected content of one result
  typedef struct {
    status_t     status;
    logic [31:0] value;
    logic [15:0] prio;
    logic [4:0]  occ;
  } queue_res_t;

  // one stored entry of the shadow queue
  typedef struct {
    logic [15:0] prio;
    logic [31:0] value;
  } slot_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  queue_req_t request_backlog[$];
  queue_res_t pending_results[$];
  slot_t      queued_entries[$];

  int req_sent = 0;
  int req_done = 0;
  int res_done = 0;
  int res_seen = 0;
  int mismatch_count = 0;
  int send_gap = 0;
  int recv_stall = 0;
  bit recv_hold = 1'b0;

  stable_priority_queue_unit #(
    .CAPACITY     (DEPTH),
    .PRIORITY_BITS(16)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // shadow queue update for one accepted request, pushes the expected result
  task automatic apply_request(input cmd_t c, input logic [31:0] v, input logic [15:0] p);
    queue_res_t r;
    slot_t      s;
    int         pos;
    r.value = '0;
    r.prio  = '0;
    if (c == CMD_INSERT) begin
      if (queued_entries.size() >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // new entry goes behind every entry of lower or equal priority
        pos = 0;
        while (pos < queued_entries.size() && $signed(queued_entries[pos].prio) <= $signed(p))
          pos++;
        s.prio  = p;
        s.value = v;
        queued_entries.insert(pos, s);
        r.status = ST_INSERTED;
      end
    end else if (queued_entries.size() == 0) begin
      r.status = ST_UNDERFLOW;
    end else begin
      s = queued_entries.pop_front();
      r.value  = s.value;
      r.prio   = s.prio;
      r.status = ST_REMOVED;
    end
    r.occ = 5'(queued_entries.size());
    pending_results.push_back(r);
  endtask

  task automatic report_field(input string what, input logic [63:0] want, input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch at result %0d, %s: expected %h, got %h", res_done, what, want, got);
  endtask

  task automatic add_request(input cmd_t c, input logic [31:0] v, input logic [15:0] p,
                             input bit pause);
    queue_req_t q;
    q.cmd   = c;
    q.value = v;
    q.prio  = p;
    q.pause = pause;
    request_backlog.push_back(q);
  endtask

  // priorities lean on extremes and a narrow band so ties are common
  function automatic logic [15:0] pick_priority();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      4, 5, 6, 7: return 16'($urandom_range(0, 6)) - 16'd3;
      default: return 16'($urandom);
    endcase
  endfunction

  // request acceptance and result checking at the rising edge
  always @(posedge clk) begin
    queue_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_field("unexpected result, status", '0, 64'(m_axis_tuser));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status)
          report_field("status", 64'(want.status), 64'(m_axis_tuser));
        if (m_axis_tdata[31:0] !== want.value)
          report_field("out_value", 64'(want.value), 64'(m_axis_tdata[31:0]));
        if (m_axis_tdata[47:32] !== want.prio)
          report_field("out_priority", 64'(want.prio), 64'(m_axis_tdata[47:32]));
        if (m_axis_tdata[52:48] !== want.occ)
          report_field("occupancy", 64'(want.occ), 64'(m_axis_tdata[52:48]));
        if (m_axis_tdata[55:53] !== 3'b000)
          report_field("padding", '0, 64'(m_axis_tdata[55:53]));
      end
      res_done++;
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      apply_request(cmd_t'(s_axis_tuser[0]), s_axis_tdata[31:0], s_axis_tdata[47:32]);
      req_done++;
    end
  end

  // request driver, changes inputs at the falling edge
  always @(negedge clk) begin
    logic        v;
    logic [47:0] d;
    logic [0:0]  u;
    queue_req_t  nx;
    int          phase;
    v = s_axis_tvalid;
    d = s_axis_tdata;
    u = s_axis_tuser;
    phase = (req_done / 64) % 4;
    if (!rst) begin
      if (v && req_done == req_sent) begin
        v = 1'b0;
        send_gap = (phase == 1 || phase == 3) ? 0 : $urandom_range(0, 13);
      end
      if (!v) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (request_backlog.size() != 0 &&
                     !(request_backlog[0].pause &&
                       (pending_results.size() != 0 || req_done != req_sent))) begin
          nx = request_backlog.pop_front();
          v = 1'b1;
          d = {nx.prio, nx.value};
          u = nx.cmd;
          req_sent++;
        end
      end
    end
    s_axis_tvalid <= v;
    s_axis_tdata  <= d;
    s_axis_tuser  <= u;
  end

  // result receiver with per-result stalls
  always @(negedge clk) begin
    logic r;
    int   phase;
    phase = (req_done / 64) % 4;
    if (rst) begin
      r = 1'b0;
    end else begin
      if (res_done != res_seen) begin
        res_seen = res_done;
        recv_stall = (phase >= 2) ? 0 : $urandom_range(0, 13);
      end
      if (recv_hold) begin
        r = 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        r = 1'b0;
      end else begin
        r = 1'b1;
      end
    end
    m_axis_tready <= r;
  end

  // long receiver hold-off so the queue backs up into the input
  initial begin
    wait (req_done >= 300);
    @(posedge clk);
    recv_hold = 1'b1;
    repeat (150) @(posedge clk);
    recv_hold = 1'b0;
  end

  initial begin
    #500000;
    $display("tb failed");
    $finish;
  end

  // stimulus and end of run
  initial begin
    int n_rand;
    int seg;
    int seg_len;
    int ins_pct;
    bit pause_seg;

    // directed: underflow, extremes, ties, drain back to empty
    add_request(CMD_REMOVE, 32'hffffffff, 16'hffff, 1'b0);
    add_request(CMD_INSERT, 32'h7fffffff, 16'h7fff, 1'b0);
    add_request(CMD_INSERT, 32'h80000000, 16'h8000, 1'b0);
    add_request(CMD_INSERT, 32'h00000000, 16'h0000, 1'b0);
    add_request(CMD_INSERT, 32'hffffffff, 16'hffff, 1'b0);
    add_request(CMD_INSERT, 32'h00000001, 16'h0000, 1'b0);
    add_request(CMD_INSERT, 32'h00000002, 16'h0000, 1'b0);
    add_request(CMD_INSERT, 32'h00000003, 16'h8000, 1'b0);
    add_request(CMD_INSERT, 32'h00000004, 16'h7fff, 1'b0);
    repeat (8) add_request(CMD_REMOVE, $urandom, 16'($urandom), 1'b0);
    add_request(CMD_REMOVE, 32'h0, 16'h0, 1'b0);

    // random: first a fill past full, then a drain past empty, then mixed segments
    n_rand = 0;
    seg = 0;
    while (n_rand < RANDOM_ITEMS) begin
      seg_len = (seg < 2) ? 20 : $urandom_range(20, 80);
      pause_seg = (seg == 0) || ($urandom_range(0, 3) == 0);
      if (seg == 0) begin
        ins_pct = 100;
      end else if (seg == 1) begin
        ins_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0: ins_pct = 85;
          1: ins_pct = 15;
          2: ins_pct = 50;
          default: ins_pct = 60;
        endcase
      end
      for (int k = 0; k < seg_len; k++) begin
        add_request(($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_REMOVE,
                    $urandom, pick_priority(), pause_seg && k == 0);
        n_rand++;
      end
      seg++;
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (request_backlog.size() != 0 || req_done != req_sent) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0)
      report_field("missing results", 64'(pending_results.size()), '0);

    if (mismatch_count == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
